// ===== design/gdrc_pkg.sv =====
// gdrc_pkg: shared types, constants and state codes for the grid ray caster
// no dependencies
package gdrc_pkg;

	localparam int MapWidth = 128;
	localparam int MapHeight = 32;
	localparam int MaxSteps = 220;
	localparam int MapDepth = MapWidth * MapHeight;
	localparam int ColW = $clog2(MapWidth);
	localparam int RowW = $clog2(MapHeight);
	localparam int AddrW = $clog2(MapDepth);
	localparam int StepW = $clog2(MaxSteps + 1);

	typedef enum logic [2:0] {
		REG_PLAYER_X = 3'd0,
		REG_PLAYER_Y = 3'd1,
		REG_MAP_COLS = 3'd2,
		REG_MAP_ROWS = 3'd3,
		REG_MAX_LEN = 3'd4,
		REG_SCREEN_ROWS = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RECIP,
		ST_SIDE,
		ST_STEP,
		ST_READ,
		ST_CHECK,
		ST_CORR,
		ST_HDIV,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [0:0] cmd;
		logic [4:0] cell_row;
		logic [6:0] cell_col;
		logic [0:0] cell_solid;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [14:0] fisheye_cos;
	} in_item_t;

	typedef struct packed {
		logic [15:0] ray_length;
		logic [15:0] corrected_dist;
		logic [11:0] wall_height;
		logic [3:0] shade;
		logic [0:0] near_wall;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input beat, start reciprocals
		logic div_step;   // one divider iteration
		logic side;       // compute first boundary distances
		logic step;       // one dda step
		logic corr;       // corrected distance
		logic hdiv_start; // start height division
		logic fin;        // build result
		logic write_cell; // store map cell
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic stop;
	} dp_stat_t;

endpackage

// ===== design/gdrc_ram.sv =====
// gdrc_ram: generic single-port ram with registered read
// no dependencies
module gdrc_ram #(
	parameter int Width = 1,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// write when enabled, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== design/gdrc_ctrl.sv =====
// gdrc_ctrl: sequencer for cell writes and ray casts
// depends on gdrc_pkg
module gdrc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_cmd,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input gdrc_pkg::dp_stat_t stat,
	output gdrc_pkg::dp_cmd_t cmd
);
	import gdrc_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && in_cmd) state_d = ST_RECIP;
			ST_RECIP: if (stat.div_done) state_d = ST_SIDE;
			ST_SIDE: state_d = ST_STEP;
			ST_STEP: state_d = ST_READ;
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: state_d = stat.stop ? ST_CORR : ST_STEP;
			ST_CORR: state_d = ST_HDIV;
			ST_HDIV: if (stat.div_done) state_d = ST_FIN;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid && in_cmd;
				cmd.write_cell = in_valid && !in_cmd;
			end
			ST_RECIP: cmd.div_step = 1'b1;
			ST_SIDE: cmd.side = 1'b1;
			ST_STEP: cmd.step = 1'b1;
			ST_CORR: begin
				cmd.corr = 1'b1;
			end
			ST_HDIV: begin
				cmd.div_step = 1'b1;
			end
			ST_FIN: cmd.fin = 1'b1;
			default: ;
		endcase
		if (state_q == ST_CORR) cmd.hdiv_start = 1'b1;
	end
endmodule

// ===== design/gdrc_dp.sv =====
// gdrc_dp: dda datapath, shared restoring divider, map store
// depends on gdrc_pkg, gdrc_ram
module gdrc_dp (
	input logic clk,
	input logic arst_n,
	input gdrc_pkg::dp_cmd_t cmd,
	input gdrc_pkg::in_item_t in_item,
	input logic [14:0] player_x,
	input logic [12:0] player_y,
	input logic [7:0] map_cols_used,
	input logic [5:0] map_rows_used,
	input logic [7:0] max_ray_length,
	input logic [9:0] screen_rows,
	output gdrc_pkg::dp_stat_t stat,
	output gdrc_pkg::out_item_t out_item
);
	import gdrc_pkg::*;

	// divider: two lanes share one counter; lane y only used for reciprocals
	logic [30:0] qx_q, qy_q;     // dividend shifting into quotient
	logic [15:0] rx_q, ry_q;     // partial remainders
	logic [15:0] mx_q, my_q;     // divisors
	logic [4:0] dcnt_q;
	logic ddone_q;
	logic [16:0] trx, try_;

	logic [14:0] fcos_q;
	logic px_pos_q, py_pos_q;
	logic [31:0] ddx_q, ddy_q, sdx_q, sdy_q, len_q;
	logic signed [9:0] cx_q, cy_q;
	logic [StepW-1:0] it_q;
	logic [15:0] l16_q, corr_q;
	logic hit_q;

	function automatic logic [15:0] mag_of(input logic signed [15:0] v);
		logic signed [16:0] w;
		begin
			w = (v == 16'sd0) ? 17'sd1 : 17'(v);
			mag_of = (w < 0) ? 16'(-w) : 16'(w);
		end
	endfunction

	assign trx = {rx_q, qx_q[30]} - {1'b0, mx_q};
	assign try_ = {ry_q, qy_q[30]} - {1'b0, my_q};

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			ddone_q <= 1'b0;
		end else if (cmd.load) begin
			dcnt_q <= 5'd31;
			ddone_q <= 1'b0;
		end else if (cmd.hdiv_start) begin
			dcnt_q <= 5'd18;
			ddone_q <= 1'b0;
		end else if (cmd.div_step) begin
			ddone_q <= (dcnt_q == 5'd1);
			if (dcnt_q != 5'd0) dcnt_q <= dcnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qx_q <= 31'h4000_0000;
			qy_q <= 31'h4000_0000;
			rx_q <= '0;
			ry_q <= '0;
			mx_q <= mag_of(in_item.dir_x);
			my_q <= mag_of(in_item.dir_y);
		end else if (cmd.hdiv_start) begin
			// dividend screen_rows*256 (18 bits) left aligned
			qx_q <= {screen_rows, 8'd0, 13'd0};
			rx_q <= '0;
			mx_q <= corr_q;
		end else if (cmd.div_step && dcnt_q != 5'd0) begin
			if (!trx[16]) begin
				rx_q <= trx[15:0];
				qx_q <= {qx_q[29:0], 1'b1};
			end else begin
				rx_q <= {rx_q[14:0], qx_q[30]};
				qx_q <= {qx_q[29:0], 1'b0};
			end
			if (!try_[16]) begin
				ry_q <= try_[15:0];
				qy_q <= {qy_q[29:0], 1'b1};
			end else begin
				ry_q <= {ry_q[14:0], qy_q[30]};
				qy_q <= {qy_q[29:0], 1'b0};
			end
		end
	end
	assign stat.div_done = ddone_q;

	// map address and limits
	logic [RowW-1:0] wr_row;
	logic [ColW-1:0] wr_col;
	logic [AddrW-1:0] ram_addr;
	logic ram_rd;
	logic oob_q;
	logic [8:0] rlim, clim;
	assign wr_row = RowW'(in_item.cell_row);
	assign wr_col = ColW'(in_item.cell_col);
	assign rlim = (map_rows_used < 6'(MapHeight)) ? 9'(map_rows_used) : 9'(MapHeight);
	assign clim = (map_cols_used < 8'(MapWidth)) ? 9'(map_cols_used) : 9'(MapWidth);
	assign ram_addr = cmd.write_cell ? {wr_row, wr_col} : {cy_q[RowW-1:0], cx_q[ColW-1:0]};

	gdrc_ram #(.Width(1), .Depth(MapDepth)) u_map (
		.clk(clk),
		.we(cmd.write_cell),
		.addr(ram_addr),
		.wdata(in_item.cell_solid),
		.rdata(ram_rd)
	);

	// dda walk
	logic [31:0] limit, nlen;
	logic [8:0] fx, fy;
	logic [40:0] px, py;
	logic take_x;
	assign limit = {8'd0, max_ray_length, 16'd0};
	assign fx = px_pos_q ? (9'd256 - 9'(player_x[7:0])) : 9'(player_x[7:0]);
	assign fy = py_pos_q ? (9'd256 - 9'(player_y[7:0])) : 9'(player_y[7:0]);
	assign px = 41'(fx) * 41'(ddx_q);
	assign py = 41'(fy) * 41'(ddy_q);
	assign take_x = sdx_q < sdy_q;
	assign nlen = take_x ? sdx_q : sdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.load) begin
			it_q <= '0;
		end else if (cmd.step) begin
			it_q <= it_q + StepW'(1);
		end else if (cmd.corr) begin
			hit_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fcos_q <= in_item.fisheye_cos;
			px_pos_q <= (in_item.dir_x >= 0);
			py_pos_q <= (in_item.dir_y >= 0);
			cx_q <= 10'(player_x[14:8]);
			cy_q <= 10'(player_y[12:8]);
			len_q <= limit;
		end
		if (cmd.side) begin
			ddx_q <= {1'b0, qx_q};
			ddy_q <= {1'b0, qy_q};
			sdx_q <= 32'({1'b0, qx_q} * 41'(fx) >> 8);
			sdy_q <= 32'({1'b0, qy_q} * 41'(fy) >> 8);
		end
		if (cmd.step) begin
			len_q <= nlen;
			if (take_x) begin
				sdx_q <= sdx_q + ddx_q;
				cx_q <= px_pos_q ? cx_q + 10'sd1 : cx_q - 10'sd1;
			end else begin
				sdy_q <= sdy_q + ddy_q;
				cy_q <= py_pos_q ? cy_q + 10'sd1 : cy_q - 10'sd1;
			end
		end
		oob_q <= cx_q < 0 || cy_q < 0 || cy_q >= 10'(rlim) || cx_q >= 10'(clim);
	end

	assign stat.stop = oob_q || ram_rd || (len_q > limit) || (it_q == StepW'(MaxSteps));

	// corrected distance
	logic [23:0] l16w;
	logic [15:0] l16_d;
	logic [31:0] cprod;
	assign l16w = len_q[31:8];
	assign l16_d = (l16w > 24'hFFFF) ? 16'hFFFF : l16w[15:0];
	assign cprod = 32'(l16_d) * 32'(fcos_q) >> 14;
	always_ff @(posedge clk) begin
		if (cmd.corr) begin
			l16_q <= l16_d;
		end
	end
	// corr_q follows the walked length, valid from the corr cycle on
	always_comb begin
		if (cprod < 32'd13) corr_q = 16'd13;
		else if (cprod > 32'hFFFF) corr_q = 16'hFFFF;
		else corr_q = cprod[15:0];
	end

	// shade: two per three whole cells, capped at 14
	logic [7:0] lcell;
	logic [3:0] shade_d;
	assign lcell = l16_q[15:8];
	always_comb begin
		priority if (lcell >= 8'd21) shade_d = 4'd14;
		else if (lcell >= 8'd18) shade_d = 4'd12;
		else if (lcell >= 8'd15) shade_d = 4'd10;
		else if (lcell >= 8'd12) shade_d = 4'd8;
		else if (lcell >= 8'd9) shade_d = 4'd6;
		else if (lcell >= 8'd6) shade_d = 4'd4;
		else if (lcell >= 8'd3) shade_d = 4'd2;
		else shade_d = 4'd0;
	end

	// result
	logic [11:0] cap;
	assign cap = 12'(screen_rows) * 12'd3;
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_item.ray_length <= l16_q;
			out_item.corrected_dist <= corr_q;
			out_item.wall_height <= (qx_q[17:0] > 18'(cap)) ? cap : qx_q[11:0];
			out_item.shade <= shade_d;
			out_item.near_wall <= (l16_q < 16'd1024);
		end
	end
	logic unused;
	assign unused = hit_q ^ ^px ^ ^py;
endmodule

// ===== design/grid_dda_ray_caster_core.sv =====
// grid_dda_ray_caster_core: top level of the grid ray caster
// depends on gdrc_pkg, gdrc_ctrl, gdrc_dp
// a cell write is taken while idle; a cast runs the reciprocal divider, then for each dda
// step the step, map read and check states, then the height divider, then the result beat
// one item at a time, next beat taken in the cycle after the result beat is accepted
// reset returns control to idle and loads the configuration registers with defaults
module grid_dda_ray_caster_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input gdrc_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output gdrc_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [14:0] cfg_data
);
	import gdrc_pkg::*;

	logic [14:0] player_x_q;
	logic [12:0] player_y_q;
	logic [7:0] cols_q, len_max_q;
	logic [5:0] rows_q;
	logic [9:0] scr_q;
	dp_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= 15'd128;
			player_y_q <= 13'd128;
			cols_q <= 8'd80;
			rows_q <= 6'd24;
			len_max_q <= 8'd40;
			scr_q <= 10'd24;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PLAYER_X: player_x_q <= cfg_data;
				REG_PLAYER_Y: player_y_q <= cfg_data[12:0];
				REG_MAP_COLS: cols_q <= cfg_data[7:0];
				REG_MAP_ROWS: rows_q <= cfg_data[5:0];
				REG_MAX_LEN: len_max_q <= cfg_data[7:0];
				REG_SCREEN_ROWS: scr_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	gdrc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_cmd(in_data.cmd), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	gdrc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_data),
		.player_x(player_x_q), .player_y(player_y_q),
		.map_cols_used(cols_q), .map_rows_used(rows_q),
		.max_ray_length(len_max_q), .screen_rows(scr_q),
		.stat(stat), .out_item(out_data)
	);
endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for the grid ray caster core
// depends on gdrc_pkg and grid_dda_ray_caster_core; predicts each cast in place
`timescale 1ns / 100ps

module testbench;
	import gdrc_pkg::*;

	localparam int WatchLimit = 20000;
	// region that the map fill surrounds with a wall
	localparam int FillRows = 16;
	localparam int FillCols = 32;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [14:0] cfg_data;

	// predictor copy of registers and map
	int unsigned pos_x, pos_y, cols_used, rows_used, len_limit, scr_rows;
	bit wall_map [MapHeight][MapWidth];
	out_item_t hit_queue[$];
	int unsigned err_count;
	int unsigned cast_count;
	int unsigned write_count;
	int unsigned idle_cycles = 0;
	bit no_gaps;

	grid_dda_ray_caster_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// map lookup with out-of-bounds cells as walls
	function automatic bit is_wall(int r, int c);
		int rl;
		int cl;
		rl = rows_used < MapHeight ? rows_used : MapHeight;
		cl = cols_used < MapWidth ? cols_used : MapWidth;
		if (r < 0 || c < 0 || r >= rl || c >= cl) return 1'b1;
		return wall_map[r][c];
	endfunction

	// per-axis dda setup: step, cell distance, first boundary distance, start cell
	function automatic void axis_init(input logic signed [15:0] d, input int unsigned pos,
		output int stp, output longint unsigned dlt, output longint unsigned sd,
		output int cell_idx);
		int v;
		longint unsigned mag;
		longint unsigned bnd_dist;
		v = d;
		if (v == 0) v = 1;
		mag = v < 0 ? -v : v;
		dlt = (64'd1 << 30) / mag;
		cell_idx = pos >> 8;
		bnd_dist = v > 0 ? 256 - (pos & 255) : (pos & 255);
		sd = (bnd_dist * dlt) >> 8;
		stp = v > 0 ? 1 : -1;
	endfunction

	function automatic out_item_t cast_ray(in_item_t it);
		int sx, sy, mx, my;
		longint unsigned ddx, ddy, sdx, sdy, len, lim, corr, hgt, cap, shd;
		out_item_t r;
		axis_init(it.dir_x, pos_x, sx, ddx, sdx, mx);
		axis_init(it.dir_y, pos_y, sy, ddy, sdy, my);
		lim = longint'(len_limit) << 16;
		len = lim;
		for (int k = 0; k < MaxSteps; k++) begin
			if (sdx < sdy) begin
				len = sdx; sdx += ddx; mx += sx;
			end else begin
				len = sdy; sdy += ddy; my += sy;
			end
			if (is_wall(my, mx) || len > lim) break;
		end
		len = len >> 8;
		if (len > 65535) len = 65535;
		corr = (len * it.fisheye_cos) >> 14;
		if (corr < 13) corr = 13;
		if (corr > 65535) corr = 65535;
		hgt = (longint'(scr_rows) * 256) / corr;
		cap = 3 * scr_rows;
		if (hgt > cap) hgt = cap;
		shd = (len / 768) * 2;
		if (shd > 14) shd = 14;
		r.ray_length = len[15:0];
		r.corrected_dist = corr[15:0];
		r.wall_height = hgt[11:0];
		r.shade = shd[3:0];
		r.near_wall = len < 1024;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		err_count++;
	endtask

	// send one input beat, update the predictor on acceptance
	task automatic send_item(input in_item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (it.cmd == 1'b0) begin
			wall_map[it.cell_row][it.cell_col] = it.cell_solid;
			write_count++;
		end else begin
			hit_queue.push_back(cast_ray(it));
			cast_count++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (hit_queue.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// register write; only called with the core idle
	task automatic write_reg(input reg_idx_t idx, input int unsigned val);
		drain();
		cfg_index <= idx;
		cfg_data <= val[14:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PLAYER_X: pos_x = val & 16'h7FFF;
			REG_PLAYER_Y: pos_y = val & 16'h1FFF;
			REG_MAP_COLS: cols_used = val & 8'hFF;
			REG_MAP_ROWS: rows_used = val & 8'h3F;
			REG_MAX_LEN: len_limit = val & 8'hFF;
			REG_SCREEN_ROWS: scr_rows = val & 16'h3FF;
			default: ;
		endcase
	endtask

	task automatic set_all(input int unsigned px, py, mc, mr, ml, sr);
		write_reg(REG_PLAYER_X, px);
		write_reg(REG_PLAYER_Y, py);
		write_reg(REG_MAP_COLS, mc);
		write_reg(REG_MAP_ROWS, mr);
		write_reg(REG_MAX_LEN, ml);
		write_reg(REG_SCREEN_ROWS, sr);
	endtask

	function automatic in_item_t cast_item(logic signed [15:0] dx, logic signed [15:0] dy,
		int unsigned fc);
		in_item_t it;
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		it = rnd[$bits(in_item_t)-1:0];
		it.cmd = 1'b1;
		it.dir_x = dx;
		it.dir_y = dy;
		it.fisheye_cos = fc[14:0];
		return it;
	endfunction

	function automatic in_item_t cell_item(int unsigned r, int unsigned c, bit s);
		in_item_t it;
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		it = rnd[$bits(in_item_t)-1:0];
		it.cmd = 1'b0;
		it.cell_row = r[4:0];
		it.cell_col = c[6:0];
		it.cell_solid = s;
		return it;
	endfunction

	function automatic logic signed [15:0] rand_dir();
		int unsigned p;
		p = $urandom_range(0, 9);
		if (p == 0) return 16'sd0;
		if (p == 1) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	// fill the test region: walled border, scattered pillars
	task automatic test_map_fill();
		no_gaps = 1'b1;
		for (int r = 0; r < FillRows; r++)
			for (int c = 0; c < FillCols; c++)
				send_item(cell_item(r, c, r == 0 || c == 0 || r == FillRows - 1 ||
					c == FillCols - 1 || $urandom_range(0, 9) == 0));
		no_gaps = 1'b0;
	endtask

	// axis rays, zero and full-scale components, fisheye extremes
	task automatic test_directed();
		set_all(5 * 256 + 128, 5 * 256 + 128, 80, 24, 40, 24);
		send_item(cast_item(16'sd16384, 16'sd0, 16384));
		send_item(cast_item(-16'sd16384, 16'sd0, 16384));
		send_item(cast_item(16'sd0, 16'sd16384, 0));
		send_item(cast_item(16'sd0, -16'sd16384, 16384));
		send_item(cast_item(16'sd0, 16'sd0, 16384));
		send_item(cast_item(16'sd11585, 16'sd11585, 11585));
		send_item(cast_item(-16'sd11585, -16'sd11585, 1));
		send_item(cast_item(16'sd1, -16'sd1, 32767));
		send_item(cast_item(16'sd16384, 16'sd1, 16384));
		// place a wall next to the player and cast into it, then open it and cast again
		send_item(cell_item(5, 6, 1'b1));
		send_item(cast_item(16'sd16384, 16'sd0, 16384));
		send_item(cell_item(5, 6, 1'b0));
		send_item(cast_item(16'sd16384, 16'sd0, 16384));
	endtask

	// random writes inside the border and casts under one register setting
	task automatic run_mix(input int n);
		int unsigned r, c;
		for (int k = 0; k < n; k++) begin
			if (k % 100 == 50) no_gaps = ~no_gaps;
			if ($urandom_range(0, 3) == 0) begin
				r = $urandom_range(1, FillRows - 2);
				c = $urandom_range(1, FillCols - 2);
				send_item(cell_item(r, c, $urandom_range(0, 5) == 0));
			end else begin
				send_item(cast_item(rand_dir(), rand_dir(), $urandom_range(0, 16384)));
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_settings_sweep();
		set_all(0, 0, 128, 32, 255, 1023);
		run_mix(200);
		set_all(32767, 8191, 1, 1, 1, 1);
		run_mix(100);
		set_all(3 * 256 + 17, 2 * 256 + 200, 255, 63, 255, 0);
		run_mix(200);
		// sender holds off until every pending cast has come back
		drain();
		run_mix(50);
		for (int p = 0; p < 3; p++) begin
			set_all($urandom_range(0, (FillCols - 1) * 256 - 1),
				$urandom_range(0, (FillRows - 1) * 256 - 1),
				$urandom_range(1, 128), $urandom_range(1, 32), $urandom_range(1, 255),
				$urandom_range(1, 1023));
			run_mix(200);
		end
		set_all(20 * 256, 10 * 256, 80, 24, 40, 24);
		run_mix(150);
	endtask

	// result side: random stalls per beat, with stretches of none
	initial begin
		int w;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			w = no_gaps ? 0 : $urandom_range(0, 15);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each result beat with the oldest predicted hit
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (hit_queue.size() == 0) begin
				report_mismatch("unexpected result beat", 1, 0);
			end else begin
				want = hit_queue.pop_front();
				if (out_data.ray_length !== want.ray_length)
					report_mismatch("ray_length", out_data.ray_length, want.ray_length);
				if (out_data.corrected_dist !== want.corrected_dist)
					report_mismatch("corrected_dist", out_data.corrected_dist,
						want.corrected_dist);
				if (out_data.wall_height !== want.wall_height)
					report_mismatch("wall_height", out_data.wall_height, want.wall_height);
				if (out_data.shade !== want.shade)
					report_mismatch("shade", out_data.shade, want.shade);
				if (out_data.near_wall !== want.near_wall)
					report_mismatch("near_wall", out_data.near_wall, want.near_wall);
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("timeout with %0d results pending", hit_queue.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		err_count = 0;
		cast_count = 0;
		write_count = 0;
		no_gaps = 1'b0;
		pos_x = 128;
		pos_y = 128;
		cols_used = 80;
		rows_used = 24;
		len_limit = 40;
		scr_rows = 24;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_map_fill();
		test_directed();
		test_settings_sweep();
		drain();
		repeat (800) @(posedge clk);
		if (hit_queue.size() != 0) report_mismatch("results left over", hit_queue.size(), 0);
		$display("covered %0d cell writes and %0d ray casts over eight register settings",
			write_count, cast_count);
		$display("mismatches: %0d", err_count);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
